[rtl/iecho_pkg.sv]
// ----------------------------------------------------------------------------
// ICMP echo reply rewriter package
// Shared types and constants for the echo reply rewriter.
// ----------------------------------------------------------------------------
`default_nettype none

package iecho_pkg;

  localparam int unsigned HdrLen = 38;
  localparam logic [5:0] LastIdx = 6'(HdrLen - 1);

  localparam logic [7:0]  ProtoIcmp   = 8'd1;
  localparam logic [7:0]  IcmpEchoReq = 8'd8;
  localparam logic [7:0]  IcmpEchoRep = 8'd0;
  localparam logic [15:0] CksumAdd    = 16'h0800;
  localparam logic [31:0] OwnIpReset  = 32'h810a735e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } frame_in_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
  } reply_out_t;

  typedef logic [HdrLen-1:0][7:0] hdr_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    StCollect,
    StCheck,
    StEmit,
    StPass,
    StDrop
  } state_e;

endpackage

`default_nettype wire

[rtl/iecho_cell.sv]
// ----------------------------------------------------------------------------
// Header byte cell
// One byte of the header chain: shifts from its neighbor or loads an edit.
// ----------------------------------------------------------------------------
`default_nettype none

module iecho_cell (
  input  wire logic                 clk_i,
  input  wire iecho_pkg::cell_ctrl_t ctrl_i,
  input  wire logic [7:0]           next_byte_i,
  input  wire logic [7:0]           load_byte_i,
  output logic [7:0]                byte_o
);
  import iecho_pkg::*;

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctrl_i.shift) begin
      byte_d = next_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

[rtl/iecho_edit.sv]
// ----------------------------------------------------------------------------
// Echo request match and reply edit
// Checks a buffered header for an echo request and builds the reply header.
// ----------------------------------------------------------------------------
`default_nettype none

module iecho_edit (
  input  wire iecho_pkg::hdr_t hdr_i,
  input  wire logic [31:0]     own_ip_i,
  output logic                 match_o,
  output iecho_pkg::hdr_t      reply_o
);
  import iecho_pkg::*;

  logic [31:0] dst_ip;
  logic [16:0] ck_sum;
  logic [15:0] ck_new;

  assign dst_ip = {hdr_i[30], hdr_i[31], hdr_i[32], hdr_i[33]};
  assign match_o = (dst_ip == own_ip_i) && (hdr_i[23] == ProtoIcmp) &&
                   (hdr_i[34] == IcmpEchoReq);

  // ones' complement add: fold the carry back in
  assign ck_sum = {1'b0, hdr_i[36], hdr_i[37]} + {1'b0, CksumAdd};
  assign ck_new = ck_sum[15:0] + {15'd0, ck_sum[16]};

  always_comb begin
    reply_o = hdr_i;
    for (int i = 0; i < 6; i++) begin
      reply_o[i]     = hdr_i[i + 6];
      reply_o[i + 6] = hdr_i[i];
    end
    for (int i = 0; i < 4; i++) begin
      reply_o[26 + i] = hdr_i[30 + i];
      reply_o[30 + i] = hdr_i[26 + i];
    end
    reply_o[34] = IcmpEchoRep;
    reply_o[36] = ck_new[15:8];
    reply_o[37] = ck_new[7:0];
  end

endmodule

`default_nettype wire

[rtl/icmp_echo_reply_rewriter.sv]
// Order: a matching frame's reply starts once its 38 header bytes are in,
//   after the check state loads the edits and the output register is filled.
// Throughput: header bytes enter one per cycle; payload bytes, and the 38-cell
//   header chain (input held), leave one per cycle while the output is free.
// Reset: control returns to header collection and the address register to
//   its default; the header chain holds no reset value.
// ----------------------------------------------------------------------------
// ICMP echo reply rewriter
// Turns incoming ICMP echo requests for our address into echo replies.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_reply_rewriter (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [31:0]            cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire iecho_pkg::frame_in_t   in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output iecho_pkg::reply_out_t       out_data_o
);
  import iecho_pkg::*;

  state_e      state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        last_q, last_d;
  logic [31:0] own_ip_q;
  logic        out_valid_q, out_valid_d;
  reply_out_t  out_q, out_d;

  cell_ctrl_t  cell_ctrl;
  hdr_t        hdr;
  hdr_t        reply_hdr;
  logic        match;
  logic        in_acc;
  logic        out_free;

  for (genvar k = 0; k < HdrLen; k++) begin : g_cell
    logic [7:0] nxt;
    if (k == HdrLen - 1) begin : g_tail
      assign nxt = in_data_i.frame_byte;
    end else begin : g_body
      assign nxt = hdr[k + 1];
    end
    iecho_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .next_byte_i (nxt),
      .load_byte_i (reply_hdr[k]),
      .byte_o      (hdr[k])
    );
  end

  iecho_edit u_edit (
    .hdr_i    (hdr),
    .own_ip_i (own_ip_q),
    .match_o  (match),
    .reply_o  (reply_hdr)
  );

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    last_d          = last_q;
    out_valid_d     = out_valid_q && out_stall_i;
    out_d           = out_q;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.load  = 1'b0;
    in_stall_o      = 1'b1;
    unique case (state_q)
      StCollect: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cell_ctrl.shift = 1'b1;
          if (cnt_q == LastIdx) begin
            cnt_d   = '0;
            last_d  = in_data_i.end_of_frame;
            state_d = StCheck;
          end else if (in_data_i.end_of_frame) begin
            cnt_d = '0;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      StCheck: begin
        if (match) begin
          cell_ctrl.load = 1'b1;
          state_d        = StEmit;
        end else begin
          state_d = last_q ? StCollect : StDrop;
        end
      end
      StEmit: begin
        if (out_free) begin
          cell_ctrl.shift = 1'b1;
          out_valid_d     = 1'b1;
          out_d.reply_byte = hdr[0];
          out_d.reply_last = last_q && (cnt_q == LastIdx);
          if (cnt_q == LastIdx) begin
            cnt_d   = '0;
            state_d = last_q ? StCollect : StPass;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      StPass: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          out_valid_d = 1'b1;
          out_d.reply_byte = in_data_i.frame_byte;
          out_d.reply_last = in_data_i.end_of_frame;
          if (in_data_i.end_of_frame) begin
            state_d = StCollect;
          end
        end
      end
      StDrop: begin
        in_stall_o = 1'b0;
        if (in_valid_i && in_data_i.end_of_frame) begin
          state_d = StCollect;
        end
      end
      default: begin
        state_d = StCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StCollect;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      own_ip_q    <= OwnIpReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        own_ip_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // hold input while the header chain is checked or shifted out
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck || state_q == StEmit) |-> in_stall_o)
    else $error("input taken during header check or emission");

  a_check_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck) |=> (state_q != StCheck))
    else $error("check state held for more than one cycle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastIdx)
    else $error("header position out of range");

  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPass && in_acc && in_data_i.end_of_frame) |=>
      (state_q == StCollect && out_valid_o && out_data_o.reply_last))
    else $error("payload end did not close the reply frame");

endmodule

`default_nettype wire

[tb/icmp_echo_reply_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICMP echo reply checker
// Watches the config, frame and reply channels of the echo reply rewriter,
// predicts the reply bytes of every accepted frame byte and compares each
// accepted reply transaction against the oldest prediction.
// ----------------------------------------------------------------------------

module icmp_echo_reply_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [31:0]           cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  iecho_pkg::frame_in_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  iecho_pkg::reply_out_t out_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  import iecho_pkg::*;

  typedef enum logic [1:0] {
    Collecting,
    Passing,
    Dropping
  } rx_mode_e;

  logic [7:0]  hdr_buf [HdrLen];
  int unsigned hdr_count;
  rx_mode_e    rx_mode;
  logic [31:0] own_ip;
  reply_out_t  expected_replies[$];

  function automatic logic echo_for_us();
    return {hdr_buf[30], hdr_buf[31], hdr_buf[32], hdr_buf[33]} == own_ip &&
           hdr_buf[23] == ProtoIcmp && hdr_buf[34] == IcmpEchoReq;
  endfunction

  task automatic predict_frame_byte(input frame_in_t item);
    logic [16:0] sum;
    logic [15:0] cksum;
    reply_out_t  reply;
    int unsigned k;
    case (rx_mode)
      Collecting: begin
        hdr_buf[hdr_count] = item.frame_byte;
        hdr_count++;
        if (hdr_count < HdrLen) begin
          if (item.end_of_frame) hdr_count = 0;
        end else begin
          hdr_count = 0;
          if (!echo_for_us()) begin
            rx_mode = item.end_of_frame ? Collecting : Dropping;
          end else begin
            // ones' complement add: fold the carry out of bit 15 back in
            sum   = {1'b0, hdr_buf[36], hdr_buf[37]} + {1'b0, CksumAdd};
            cksum = sum[15:0] + 16'(sum[16]);
            for (k = 0; k < HdrLen; k++) begin
              if (k < 6) reply.reply_byte = hdr_buf[k + 6];
              else if (k < 12) reply.reply_byte = hdr_buf[k - 6];
              else if (k >= 26 && k < 30) reply.reply_byte = hdr_buf[k + 4];
              else if (k >= 30 && k < 34) reply.reply_byte = hdr_buf[k - 4];
              else if (k == 34) reply.reply_byte = IcmpEchoRep;
              else if (k == 36) reply.reply_byte = cksum[15:8];
              else if (k == 37) reply.reply_byte = cksum[7:0];
              else reply.reply_byte = hdr_buf[k];
              reply.reply_last = item.end_of_frame && (k == HdrLen - 1);
              expected_replies.push_back(reply);
            end
            rx_mode = item.end_of_frame ? Collecting : Passing;
          end
        end
      end
      Passing: begin
        reply.reply_byte = item.frame_byte;
        reply.reply_last = item.end_of_frame;
        expected_replies.push_back(reply);
        if (item.end_of_frame) rx_mode = Collecting;
      end
      default: begin
        if (item.end_of_frame) begin
          rx_mode   = Collecting;
          hdr_count = 0;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    reply_out_t oldest;
    if (!rst_ni) begin
      own_ip       = OwnIpReset;
      hdr_count    = 0;
      rx_mode      = Collecting;
      expected_replies.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) own_ip = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_frame_byte(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply transaction: reply_byte %0h reply_last %0b",
                 out_data_i.reply_byte, out_data_i.reply_last);
          fail_count_o++;
        end else begin
          oldest = expected_replies.pop_front();
          if (out_data_i.reply_byte !== oldest.reply_byte) begin
            $error("reply_byte mismatch: expected %0h, actual %0h",
                   oldest.reply_byte, out_data_i.reply_byte);
            fail_count_o++;
          end
          if (out_data_i.reply_last !== oldest.reply_last) begin
            $error("reply_last mismatch: expected %0b, actual %0b",
                   oldest.reply_last, out_data_i.reply_last);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

[tb/tb_icmp_echo_reply_rewriter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ICMP echo reply rewriter testbench
// Drives directed and random Ethernet frames with random gaps and stalls,
// switches the own address between phases, and reports the verdict from the
// checker's failure count.
// ----------------------------------------------------------------------------

module tb_icmp_echo_reply_rewriter;
  import iecho_pkg::*;

  localparam int unsigned IdleCycles = 48;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned Limit      = 500000;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  frame_in_t   in_data;
  logic        out_valid;
  logic        out_stall;
  reply_out_t  out_data;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;

  logic [7:0]  frame_q[$];
  logic [31:0] cur_ip;
  logic        no_idle;
  logic        hold_req;
  int unsigned sent_bytes;

  icmp_echo_reply_rewriter i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  icmp_echo_reply_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Fill frame_q with random bytes, then place the fields the block checks.
  task automatic make_frame(input logic [31:0] dst, input logic [7:0] proto,
                            input logic [7:0] icmp_type, input logic [15:0] cksum,
                            input int unsigned len);
    int unsigned k;
    frame_q.delete();
    for (k = 0; k < len; k++) frame_q.push_back(8'($urandom));
    if (len > 23) frame_q[23] = proto;
    for (k = 0; k < 4; k++) begin
      if (30 + k < len) frame_q[30 + k] = dst[8 * (3 - k) +: 8];
    end
    if (len > 34) frame_q[34] = icmp_type;
    if (len > 36) frame_q[36] = cksum[15:8];
    if (len > 37) frame_q[37] = cksum[7:0];
  endtask

  task automatic send_byte(input frame_in_t item);
    int unsigned roll;
    int unsigned gap;
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    @(negedge clk);
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) gap = 0;
    else if (roll < 88) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_frame();
    frame_in_t   item;
    int unsigned k;
    no_idle = ($urandom_range(0, 4) == 0);
    for (k = 0; k < frame_q.size(); k++) begin
      item.frame_byte   = frame_q[k];
      item.end_of_frame = (k == frame_q.size() - 1);
      send_byte(item);
    end
    // drop valid so the last byte is not offered again
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_own_ip(input logic [31:0] ip);
    // drain, then let a dropped frame's tail work through the block
    wait (pending == 0);
    repeat (IdleCycles) @(negedge clk);
    cfg_data  <= ip;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_ip = ip;
  endtask

  // Reply side: random stall runs, plus one long hold-off on request.
  initial begin : receiver
    int unsigned run_left;
    logic        run_stall;
    out_stall = 1'b0;
    run_left  = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          run_stall = ($urandom_range(0, 2) == 0);
          if (run_stall) begin
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
          end else begin
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                   : $urandom_range(1, 12);
          end
        end
        run_left--;
        out_stall <= run_stall;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < Limit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("icmp_echo_reply_rewriter test failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [7:0]  icmp_type;
    logic [15:0] cksum;

    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    sent_bytes = 0;
    cur_ip     = OwnIpReset;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed frames at the reset address.
    // header is the whole frame; checksum carry wraps around
    make_frame(cur_ip, ProtoIcmp, IcmpEchoReq, 16'hF800, 38);
    send_frame();
    make_frame(cur_ip, ProtoIcmp, IcmpEchoReq, 16'hFFFF, 39);
    send_frame();
    // short frame
    make_frame(cur_ip, ProtoIcmp, IcmpEchoReq, 16'h0000, 1);
    send_frame();

    // Hold the reply side off while a long request keeps coming.
    hold_req = 1'b1;
    make_frame(cur_ip, ProtoIcmp, IcmpEchoReq, 16'h5A5A, 38 + 4);
    send_frame();
    // pause until every reply byte is out
    wait (pending == 0);

    // Random frames, one address setting per phase.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       write_own_ip(32'h0000_0000);
        1:       write_own_ip(32'hFFFF_FFFF);
        default: write_own_ip($urandom);
      endcase
      start = sent_bytes;
      while (sent_bytes - start < 30) begin
        pick      = $urandom_range(0, 99);
        dst       = cur_ip;
        proto     = ProtoIcmp;
        icmp_type = IcmpEchoReq;
        cksum     = ($urandom_range(0, 3) == 0) ? 16'hF7F0 + 16'($urandom_range(0, 31))
                                                : 16'($urandom);
        len       = ($urandom_range(0, 7) == 0) ? 38 + $urandom_range(0, 40)
                                                : 38 + $urandom_range(0, 6);
        if (pick >= 85) begin
          len = $urandom_range(1, 37);
        end else if (pick >= 65) begin
          case ($urandom_range(0, 2))
            0: dst = cur_ip ^ (32'h1 << $urandom_range(0, 31));
            1: begin
              proto = 8'($urandom);
              if (proto == ProtoIcmp) proto = 8'd17;
            end
            default: begin
              icmp_type = 8'($urandom);
              if (icmp_type == IcmpEchoReq) icmp_type = IcmpEchoRep;
            end
          endcase
        end
        make_frame(dst, proto, icmp_type, cksum, len);
        send_frame();
      end
    end

    wait (pending == 0);
    repeat (IdleCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("icmp_echo_reply_rewriter test passed");
    end else begin
      $display("icmp_echo_reply_rewriter test failed");
    end
    $finish;
  end

endmodule
